// File: rtl/core/plds_pkg.sv
// ----------------------------------------------------------------------------
// plds_pkg
// Shared widths, register codes and stage payload types for the point light
// diffuse shader core.
// ----------------------------------------------------------------------------
package plds_pkg;

    localparam int NUM_CH    = 3;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MAG_W     = COORD_W - 1;
    localparam int NORM_W    = 16;
    localparam int COL_W     = 16;
    localparam int SHAD_W    = 15;
    localparam int POW_W     = 32;
    localparam int LIT_W     = 32;
    localparam int SQR_W     = 2 * MAG_W;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int PROD_W    = NORM_W + MAG_W + 1;
    localparam int DOTS_W    = PROD_W + 2;
    localparam int DOT_W     = PROD_W;
    localparam int X0_W      = 2 * COL_W;
    localparam int SHAD_FRAC = 14;
    localparam int POW_FRAC  = 16;
    localparam int K_FRAC    = 28;
    localparam int X1_W      = X0_W + SHAD_W - SHAD_FRAC;
    localparam int X2_W      = X1_W + POW_W - POW_FRAC;
    localparam int K_W       = 32;
    localparam int X2_LO_W   = 32;
    localparam int X2_HI_W   = X2_W - X2_LO_W;
    localparam int PLO_W     = X2_LO_W + K_W;
    localparam int PHI_W     = X2_HI_W + K_W;
    localparam int PSUM_W    = X2_W + K_W;
    localparam int X3_W      = PSUM_W - K_FRAC;
    localparam int NUM_W     = 72;
    localparam int ATT_SH_E0 = 20;
    localparam int ATT_SH_E1 = 18;
    localparam int NUM_HI_W  = NUM_W - LIT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = NUM_CH * LIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POWER   = 3'd6;

    localparam logic [COL_W-1:0] COL_RESET = 16'd16384;
    localparam logic [POW_W-1:0] POW_RESET = 32'd65536;
    localparam logic [LIT_W-1:0] LIT_MAX   = '1;

    typedef struct packed {
        logic [SQ_W-1:0]               q;
        logic                          e;
        logic                          zero;
        logic [NUM_CH-1:0][X2_W-1:0]   x2;
    } core_t;

    typedef struct packed {
        logic [DOT_W-1:0] dot;
        core_t            core;
    } geo_t;

    typedef struct packed {
        logic [NUM_CH-1:0][SQ_W-1:0]  rem;
        logic [NUM_CH-1:0][LIT_W-1:0] lo;
        logic [SQ_W-1:0]              q;
        logic [NUM_CH-1:0]            sat;
        logic                         zero;
    } divin_t;

    typedef struct packed {
        logic zero;
        logic sat;
    } fin_t;

endpackage

// File: rtl/core/plds_front.sv
// ----------------------------------------------------------------------------
// plds_front
// Four stages: light vector, range reduction, squares and normal products,
// squared length and dot sums; channel color products run alongside.
// ----------------------------------------------------------------------------
module plds_front (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                en,
    input  logic                                                in_vld,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::COORD_W-1:0]  hit,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::NORM_W-1:0]   normal,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::COL_W-1:0]    surf,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::SHAD_W-1:0]   shad,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::COORD_W-1:0]  pos,
    input  logic [plds_pkg::NUM_CH-1:0][plds_pkg::COL_W-1:0]    col,
    input  logic [plds_pkg::POW_W-1:0]                          power,
    output logic                                                out_vld,
    output plds_pkg::geo_t                                      out_geo
);
    import plds_pkg::*;

    logic [3:0] vld_reg;

    logic [NUM_CH-1:0][DIFF_W-1:0] d_reg;
    logic [NUM_CH-1:0][NORM_W-1:0] na_reg;
    logic [NUM_CH-1:0][X0_W-1:0]   x0_reg;
    logic [NUM_CH-1:0][SHAD_W-1:0] shad_reg;

    logic [NUM_CH-1:0][DIFF_W-1:0]        mag_full;
    logic [NUM_CH-1:0][MAG_W-1:0]         m_next;
    logic [NUM_CH-1:0][X0_W+SHAD_W-1:0]   prod1;
    logic                                 e_next;
    logic [NUM_CH-1:0][MAG_W-1:0]         m_reg;
    logic [NUM_CH-1:0]                    negb_reg;
    logic                                 eb_reg;
    logic [NUM_CH-1:0][NORM_W-1:0]        nb_reg;
    logic [NUM_CH-1:0][X1_W-1:0]          x1_reg;

    logic [NUM_CH-1:0][X1_W+POW_W-1:0]    prod2;
    logic [NUM_CH-1:0][SQR_W-1:0]         sq_reg;
    logic signed [NUM_CH-1:0][PROD_W-1:0] p_reg;
    logic [NUM_CH-1:0]                    negc_reg;
    logic                                 ec_reg;
    logic [NUM_CH-1:0][X2_W-1:0]          x2_reg;

    logic [SQ_W-1:0]           q_next;
    logic signed [DOTS_W-1:0]  dot_next;
    logic signed [DOTS_W-1:0]  term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    // light vector and surface times light color
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                d_reg[c]    <= {pos[c][COORD_W-1], pos[c]} - {hit[c][COORD_W-1], hit[c]};
                x0_reg[c]   <= X0_W'(surf[c]) * X0_W'(col[c]);
                na_reg[c]   <= normal[c];
                shad_reg[c] <= shad[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            mag_full[c] = d_reg[c][DIFF_W-1] ? DIFF_W'(-d_reg[c]) : d_reg[c];
            prod1[c]    = (X0_W+SHAD_W)'(x0_reg[c]) * (X0_W+SHAD_W)'(shad_reg[c]);
        end
        e_next = mag_full[0][MAG_W] | mag_full[1][MAG_W] | mag_full[2][MAG_W];
        for (int c = 0; c < NUM_CH; c++) begin
            m_next[c] = e_next ? mag_full[c][MAG_W:1] : mag_full[c][MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                m_reg[c]    <= m_next[c];
                negb_reg[c] <= d_reg[c][DIFF_W-1];
                nb_reg[c]   <= na_reg[c];
                x1_reg[c]   <= prod1[c][X0_W+SHAD_W-1:SHAD_FRAC];
            end
            eb_reg <= e_next;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod2[c] = (X1_W+POW_W)'(x1_reg[c]) * (X1_W+POW_W)'(power);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                sq_reg[c]   <= SQR_W'(m_reg[c]) * SQR_W'(m_reg[c]);
                p_reg[c]    <= PROD_W'($signed(nb_reg[c])) *
                               PROD_W'($signed({1'b0, m_reg[c]}));
                negc_reg[c] <= negb_reg[c];
                x2_reg[c]   <= prod2[c][X1_W+POW_W-1:POW_FRAC];
            end
            ec_reg <= eb_reg;
        end
    end

    always_comb begin
        q_next   = '0;
        dot_next = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            q_next = q_next + SQ_W'(sq_reg[c]);
            term   = DOTS_W'(p_reg[c]);
            term   = {{(DOTS_W-PROD_W){p_reg[c][PROD_W-1]}}, p_reg[c]};
            dot_next = negc_reg[c] ? dot_next - term : dot_next + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_geo.dot       <= dot_next[DOT_W-1:0];
            out_geo.core.q    <= q_next;
            out_geo.core.e    <= ec_reg;
            out_geo.core.zero <= (q_next == '0) || dot_next[DOTS_W-1] || (dot_next == '0);
            out_geo.core.x2   <= x2_reg;
        end
    end

    assign out_vld = vld_reg[3];

endmodule

// File: rtl/core/plds_isqrt.sv
// ----------------------------------------------------------------------------
// plds_isqrt
// Pipelined integer square root, one root bit per stage, with a side payload.
// ----------------------------------------------------------------------------
module plds_isqrt #(
    parameter int ROOT_W = plds_pkg::ROOT_W,
    parameter int PW     = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [2*ROOT_W-1:0] in_q,
    input  logic [PW-1:0]       in_pay,
    output logic                out_vld,
    output logic [ROOT_W-1:0]   out_root,
    output logic [PW-1:0]       out_pay
);
    import plds_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = ROOT_W + 4;

    logic                vld_reg  [ROOT_W];
    logic [REM_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [2*ROOT_W-1:0] q_reg    [ROOT_W];
    logic [PW-1:0]       pay_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic                vld_p;
        logic [REM_W-1:0]    rem_p;
        logic [ROOT_W-1:0]   root_p;
        logic [2*ROOT_W-1:0] q_p;
        logic [PW-1:0]       pay_p;
        logic [SH_W-1:0]     rem_sh;
        logic [SH_W-1:0]     trial;
        logic                ge;

        if (s == 0) begin : g_first
            assign vld_p  = in_vld;
            assign rem_p  = '0;
            assign root_p = '0;
            assign q_p    = in_q;
            assign pay_p  = in_pay;
        end else begin : g_next
            assign vld_p  = vld_reg[s-1];
            assign rem_p  = rem_reg[s-1];
            assign root_p = root_reg[s-1];
            assign q_p    = q_reg[s-1];
            assign pay_p  = pay_reg[s-1];
        end

        assign rem_sh = {rem_p, q_p[2*(ROOT_W-1-s)+1 -: 2]};
        assign trial  = {2'b00, root_p, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
                root_reg[s] <= {root_p[ROOT_W-2:0], ge};
                q_reg[s]    <= q_p;
                pay_reg[s]  <= pay_p;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_pay  = pay_reg[ROOT_W-1];

endmodule

// File: rtl/core/plds_div.sv
// ----------------------------------------------------------------------------
// plds_div
// Pipelined restoring divider, one quotient bit per stage; the upper part of
// the dividend comes in as the starting remainder and must be below the divisor.
// ----------------------------------------------------------------------------
module plds_div #(
    parameter int DEN_W = plds_pkg::SQ_W,
    parameter int QUO_W = plds_pkg::LIT_W,
    parameter int PW    = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [DEN_W-1:0] in_rem,
    input  logic [QUO_W-1:0] in_lo,
    input  logic [DEN_W-1:0] in_den,
    input  logic [PW-1:0]    in_pay,
    output logic             out_vld,
    output logic [QUO_W-1:0] out_quot,
    output logic [PW-1:0]    out_pay
);
    import plds_pkg::*;

    logic             vld_reg  [QUO_W];
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] lo_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] quot_reg [QUO_W];
    logic [PW-1:0]    pay_reg  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic             vld_p;
        logic [DEN_W-1:0] rem_p;
        logic [QUO_W-1:0] lo_p;
        logic [DEN_W-1:0] den_p;
        logic [QUO_W-1:0] quot_p;
        logic [PW-1:0]    pay_p;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign vld_p  = in_vld;
            assign rem_p  = in_rem;
            assign lo_p   = in_lo;
            assign den_p  = in_den;
            assign quot_p = '0;
            assign pay_p  = in_pay;
        end else begin : g_next
            assign vld_p  = vld_reg[s-1];
            assign rem_p  = rem_reg[s-1];
            assign lo_p   = lo_reg[s-1];
            assign den_p  = den_reg[s-1];
            assign quot_p = quot_reg[s-1];
            assign pay_p  = pay_reg[s-1];
        end

        assign trial = {rem_p, lo_p[QUO_W-1]};
        assign ge    = trial >= {1'b0, den_p};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
                lo_reg[s]   <= {lo_p[QUO_W-2:0], 1'b0};
                den_reg[s]  <= den_p;
                quot_reg[s] <= {quot_p[QUO_W-2:0], ge};
                pay_reg[s]  <= pay_p;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_quot = quot_reg[QUO_W-1];
    assign out_pay  = pay_reg[QUO_W-1];

endmodule

// File: rtl/core/plds_scale.sv
// ----------------------------------------------------------------------------
// plds_scale
// Applies the Lambert factor per channel, scales by the attenuation shift and
// prepares the final divide, flagging channels that will clamp.
// ----------------------------------------------------------------------------
module plds_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [plds_pkg::K_W-1:0]      in_k,
    input  plds_pkg::core_t               in_core,
    output logic                          out_vld,
    output plds_pkg::divin_t              out_div
);
    import plds_pkg::*;

    logic [2:0] vld_reg;

    logic [NUM_CH-1:0][PLO_W-1:0] plo_reg;
    logic [NUM_CH-1:0][PHI_W-1:0] phi_reg;
    logic [SQ_W-1:0]              q1_reg;
    logic                         e1_reg;
    logic                         zero1_reg;

    logic [NUM_CH-1:0][PSUM_W-1:0] psum;
    logic [NUM_CH-1:0][X3_W-1:0]   x3;
    logic [NUM_CH-1:0][NUM_W-1:0]  num_reg;
    logic [SQ_W-1:0]               q2_reg;
    logic                          zero2_reg;

    logic [NUM_CH-1:0]             sat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    // split partial products of the lambert multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                plo_reg[c] <= PLO_W'(in_core.x2[c][X2_LO_W-1:0]) * PLO_W'(in_k);
                phi_reg[c] <= PHI_W'(in_core.x2[c][X2_W-1:X2_LO_W]) * PHI_W'(in_k);
            end
            q1_reg    <= in_core.q;
            e1_reg    <= in_core.e;
            zero1_reg <= in_core.zero;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            psum[c] = PSUM_W'(plo_reg[c]) + {phi_reg[c], {X2_LO_W{1'b0}}};
            x3[c]   = psum[c][PSUM_W-1:K_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                num_reg[c] <= e1_reg ? (NUM_W'(x3[c]) << ATT_SH_E1)
                                     : (NUM_W'(x3[c]) << ATT_SH_E0);
            end
            q2_reg    <= q1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sat_next[c] = !zero2_reg && (SQ_W'(num_reg[c][NUM_W-1:LIT_W]) >= q2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                out_div.rem[c] <= sat_next[c] ? '0 : SQ_W'(num_reg[c][NUM_W-1:LIT_W]);
                out_div.lo[c]  <= num_reg[c][LIT_W-1:0];
            end
            out_div.q    <= q2_reg;
            out_div.sat  <= sat_next;
            out_div.zero <= zero2_reg;
        end
    end

    assign out_vld = vld_reg[2];

endmodule

// File: rtl/core/point_light_diffuse_shader_core.sv
// ----------------------------------------------------------------------------
// point_light_diffuse_shader_core
// Lambert diffuse shading of one surface hit under a point light with
// inverse-square falloff, fixed point, saturating results.
// ----------------------------------------------------------------------------
// One hit is taken every cycle while s_tready is high, and its result passes
// in order through vector math, the square root, the Lambert divide, scaling,
// the attenuation divide and the output register. A one-entry skid stage sits
// at the output, so s_tready drops only while both the output register and the
// skid hold results. Light registers must be written only while no hit is in
// flight; there is no read-back and no clearing pass after reset.
module point_light_diffuse_shader_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, surface_red,
    // surface_green, surface_blue, shadow_red, shadow_green, shadow_blue, zero pad
    input  logic [plds_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // lit_red, lit_green, lit_blue
    output logic [plds_pkg::OUT_DATA_W-1:0]    m_tdata,
    // saturated
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [plds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plds_pkg::CFG_W-1:0]         cfg_wdata
);
    import plds_pkg::*;

    localparam int HIT_OFS  = 0;
    localparam int NORM_OFS = HIT_OFS + NUM_CH * COORD_W;
    localparam int SURF_OFS = NORM_OFS + NUM_CH * NORM_W;
    localparam int SHAD_OFS = SURF_OFS + NUM_CH * COL_W;

    logic [NUM_CH-1:0][COORD_W-1:0] pos_reg;
    logic [NUM_CH-1:0][COL_W-1:0]   col_reg;
    logic [POW_W-1:0]               power_reg;

    logic [NUM_CH-1:0][COORD_W-1:0] hit;
    logic [NUM_CH-1:0][NORM_W-1:0]  normal;
    logic [NUM_CH-1:0][COL_W-1:0]   surf;
    logic [NUM_CH-1:0][SHAD_W-1:0]  shad;

    logic    en;
    logic    front_vld;
    geo_t    front_geo;
    logic    sq_vld;
    logic [ROOT_W-1:0] sq_root;
    geo_t    sq_geo;
    logic    k_vld;
    logic [K_W-1:0] k_quot;
    core_t   k_core;
    logic    sc_vld;
    divin_t  sc_div;

    logic [NUM_CH-1:0]            fin_vld;
    logic [NUM_CH-1:0][LIT_W-1:0] fin_quot;
    fin_t [NUM_CH-1:0]            fin_pay;

    logic                          pipe_vld;
    logic [OUT_DATA_W-1:0]         pipe_data;
    logic                          pipe_sat;

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_sat_reg;
    logic                  skid_vld_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;
    logic                  skid_sat_reg;
    logic                  out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            col_reg   <= {NUM_CH{COL_RESET}};
            power_reg <= POW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POS_X: pos_reg[0] <= cfg_wdata;
                REG_POS_Y: pos_reg[1] <= cfg_wdata;
                REG_POS_Z: pos_reg[2] <= cfg_wdata;
                REG_RED:   col_reg[0] <= cfg_wdata[COL_W-1:0];
                REG_GREEN: col_reg[1] <= cfg_wdata[COL_W-1:0];
                REG_BLUE:  col_reg[2] <= cfg_wdata[COL_W-1:0];
                REG_POWER: power_reg  <= cfg_wdata[POW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            hit[c]    = s_tdata[HIT_OFS  + c*COORD_W +: COORD_W];
            normal[c] = s_tdata[NORM_OFS + c*NORM_W  +: NORM_W];
            surf[c]   = s_tdata[SURF_OFS + c*COL_W   +: COL_W];
            shad[c]   = s_tdata[SHAD_OFS + c*SHAD_W  +: SHAD_W];
        end
    end

    // whole pipeline moves unless the skid holds a result
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    plds_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .hit     (hit),
        .normal  (normal),
        .surf    (surf),
        .shad    (shad),
        .pos     (pos_reg),
        .col     (col_reg),
        .power   (power_reg),
        .out_vld (front_vld),
        .out_geo (front_geo)
    );

    plds_isqrt #(
        .ROOT_W (ROOT_W),
        .PW     ($bits(geo_t))
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (front_vld),
        .in_q     (front_geo.core.q),
        .in_pay   (front_geo),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pay  (sq_geo)
    );

    // dot shifted up by SHAD_FRAC bits, top part as starting remainder
    plds_div #(
        .DEN_W (ROOT_W),
        .QUO_W (K_W),
        .PW    ($bits(core_t))
    ) u_kdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld),
        .in_rem   (ROOT_W'(sq_geo.dot[DOT_W-1:K_W-SHAD_FRAC])),
        .in_lo    ({sq_geo.dot[K_W-SHAD_FRAC-1:0], {SHAD_FRAC{1'b0}}}),
        .in_den   (sq_root),
        .in_pay   (sq_geo.core),
        .out_vld  (k_vld),
        .out_quot (k_quot),
        .out_pay  (k_core)
    );

    plds_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (k_vld),
        .in_k    (k_quot),
        .in_core (k_core),
        .out_vld (sc_vld),
        .out_div (sc_div)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        plds_div #(
            .DEN_W (SQ_W),
            .QUO_W (LIT_W),
            .PW    ($bits(fin_t))
        ) u_fdiv (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (sc_vld),
            .in_rem   (sc_div.rem[c]),
            .in_lo    (sc_div.lo[c]),
            .in_den   (sc_div.q),
            .in_pay   ({sc_div.zero, sc_div.sat[c]}),
            .out_vld  (fin_vld[c]),
            .out_quot (fin_quot[c]),
            .out_pay  (fin_pay[c])
        );
    end

    always_comb begin
        pipe_vld = &fin_vld;
        pipe_sat = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (fin_pay[c].zero) begin
                pipe_data[c*LIT_W +: LIT_W] = '0;
            end else if (fin_pay[c].sat) begin
                pipe_data[c*LIT_W +: LIT_W] = LIT_MAX;
                pipe_sat = 1'b1;
            end else begin
                pipe_data[c*LIT_W +: LIT_W] = fin_quot[c];
            end
        end
    end

    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= pipe_vld;
            end
        end else if (pipe_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_data_reg <= skid_data_reg;
                out_sat_reg  <= skid_sat_reg;
            end else begin
                out_data_reg <= pipe_data;
                out_sat_reg  <= pipe_sat;
            end
        end else if (en) begin
            skid_data_reg <= pipe_data;
            skid_sat_reg  <= pipe_sat;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

// File: rtl/core/plds_checker.sv
// ----------------------------------------------------------------------------
// plds_checker
// Port-level checks for the point light diffuse shader core.
// ----------------------------------------------------------------------------
module plds_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [plds_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                      m_tuser
);
    import plds_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // saturation flag implies a clamped channel
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[LIT_W-1:0] == LIT_MAX) ||
            (m_tdata[2*LIT_W-1:LIT_W] == LIT_MAX) ||
            (m_tdata[3*LIT_W-1:2*LIT_W] == LIT_MAX))
        else $error("saturated without clamped channel");

    // input backpressure only with a result waiting
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind point_light_diffuse_shader_core plds_checker u_plds_checker (.*);
